>>> src/vmpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmpu_pkg: shared types and constants of the pose update unit
// Command and status types between the controller and the datapath, step
// counts of the iterative units and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package vmpu_pkg;

  localparam int CordicSteps = 30;
  localparam int MulSteps    = 40;
  localparam int RcpSteps    = 58;
  localparam int DivSteps    = 64;

  localparam logic [39:0] HeadGain   = 40'd183493156455;
  // ceil(2^71 / 15625): exact quotient by 15625 for numerators below 2^57
  localparam logic [57:0] RcpMul     = 58'd151115727451828647;
  localparam logic signed [33:0] CordicStart = 34'sd652032874;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_COR_INIT0,
    OP_COR_INIT1,
    OP_COR_STEP,
    OP_SAVE0,
    OP_SAVE1,
    OP_MUL_HEAD,
    OP_MUL_STEP,
    OP_HEAD_Q1,
    OP_DIV_X,
    OP_DIV_Y,
    OP_DIV_S,
    OP_DIV_STEP,
    OP_DIVX_DONE,
    OP_DIVY_DONE,
    OP_DIVS_DONE,
    OP_SMUL_X,
    OP_SMUL_Y,
    OP_SMULX_DONE,
    OP_SMULY_DONE,
    OP_UPDATE
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_COR0_INIT, ST_COR0, ST_SAVE0,
    ST_HMUL_INIT, ST_HMUL, ST_HEAD,
    ST_COR1_INIT, ST_COR1, ST_SAVE1,
    ST_DIVX_INIT, ST_DIVX, ST_DIVX_DONE,
    ST_DIVY_INIT, ST_DIVY, ST_DIVY_DONE,
    ST_DIVS_INIT, ST_DIVS, ST_DIVS_DONE,
    ST_SMX_INIT, ST_SMX, ST_SMX_DONE,
    ST_SMY_INIT, ST_SMY, ST_SMY_DONE,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic w_zero;
  } status_t;

  // arctangent of 2^-i in binary-angle units
  function automatic logic [31:0] arc_angle(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> src/vmpu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmpu_ctrl: sequencer of the pose update unit
// Walks one sample through CORDIC, multiply and divide phases and issues one
// datapath command per cycle.
// ----------------------------------------------------------------------------
module vmpu_ctrl
  import vmpu_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q + 6'd1;
    cmd_o.op    = OP_NONE;
    cmd_o.idx   = cnt_q[4:0];
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = status_i.started ? ST_COR0_INIT : ST_OUT;
        end
      end
      ST_COR0_INIT: begin
        cmd_o.op = OP_COR_INIT0; cnt_d = '0; state_d = ST_COR0;
      end
      ST_COR0: begin
        cmd_o.op = OP_COR_STEP;
        if (cnt_q == 6'(CordicSteps - 1)) state_d = ST_SAVE0;
      end
      ST_SAVE0: begin
        cmd_o.op = OP_SAVE0;
        state_d  = status_i.w_zero ? ST_DIVS_INIT : ST_HMUL_INIT;
      end
      ST_HMUL_INIT: begin
        cmd_o.op = OP_MUL_HEAD; cnt_d = '0; state_d = ST_HMUL;
      end
      ST_HMUL: begin
        cmd_o.op = OP_MUL_STEP;
        if (cnt_q == 6'(MulSteps - 1)) state_d = ST_HEAD;
      end
      ST_HEAD: begin
        cmd_o.op = OP_HEAD_Q1; state_d = ST_COR1_INIT;
      end
      ST_COR1_INIT: begin
        cmd_o.op = OP_COR_INIT1; cnt_d = '0; state_d = ST_COR1;
      end
      ST_COR1: begin
        cmd_o.op = OP_COR_STEP;
        if (cnt_q == 6'(CordicSteps - 1)) state_d = ST_SAVE1;
      end
      ST_SAVE1: begin
        cmd_o.op = OP_SAVE1; state_d = ST_DIVX_INIT;
      end
      ST_DIVX_INIT: begin
        cmd_o.op = OP_DIV_X; cnt_d = '0; state_d = ST_DIVX;
      end
      ST_DIVX: begin
        cmd_o.op = OP_DIV_STEP;
        if (cnt_q == 6'(DivSteps - 1)) state_d = ST_DIVX_DONE;
      end
      ST_DIVX_DONE: begin
        cmd_o.op = OP_DIVX_DONE; state_d = ST_DIVY_INIT;
      end
      ST_DIVY_INIT: begin
        cmd_o.op = OP_DIV_Y; cnt_d = '0; state_d = ST_DIVY;
      end
      ST_DIVY: begin
        cmd_o.op = OP_DIV_STEP;
        if (cnt_q == 6'(DivSteps - 1)) state_d = ST_DIVY_DONE;
      end
      ST_DIVY_DONE: begin
        cmd_o.op = OP_DIVY_DONE; state_d = ST_UPDATE;
      end
      ST_DIVS_INIT: begin
        cmd_o.op = OP_DIV_S; cnt_d = '0; state_d = ST_DIVS;
      end
      ST_DIVS: begin
        // reciprocal multiply on the shared shift-add unit
        cmd_o.op = OP_MUL_STEP;
        if (cnt_q == 6'(RcpSteps - 1)) state_d = ST_DIVS_DONE;
      end
      ST_DIVS_DONE: begin
        cmd_o.op = OP_DIVS_DONE; state_d = ST_SMX_INIT;
      end
      ST_SMX_INIT: begin
        cmd_o.op = OP_SMUL_X; cnt_d = '0; state_d = ST_SMX;
      end
      ST_SMX: begin
        cmd_o.op = OP_MUL_STEP;
        if (cnt_q == 6'(MulSteps - 1)) state_d = ST_SMX_DONE;
      end
      ST_SMX_DONE: begin
        cmd_o.op = OP_SMULX_DONE; state_d = ST_SMY_INIT;
      end
      ST_SMY_INIT: begin
        cmd_o.op = OP_SMUL_Y; cnt_d = '0; state_d = ST_SMY;
      end
      ST_SMY: begin
        cmd_o.op = OP_MUL_STEP;
        if (cnt_q == 6'(MulSteps - 1)) state_d = ST_SMY_DONE;
      end
      ST_SMY_DONE: begin
        cmd_o.op = OP_SMULY_DONE; state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.op = OP_UPDATE; state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> src/vmpu_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmpu_dpath: datapath of the pose update unit
// Pose state, a shared CORDIC, a shift-add multiplier and a restoring
// divider, each advanced one step per command.
// ----------------------------------------------------------------------------
module vmpu_dpath
  import vmpu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic        [31:0] sample_time_i,
  input  logic signed [15:0] linear_speed_i,
  input  logic signed [15:0] turn_rate_i,
  output logic signed [47:0] pos_x_o,
  output logic signed [47:0] pos_y_o,
  output logic        [31:0] heading_o
);

  localparam logic signed [64:0] PosMax = 65'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [64:0] PosMin = -PosMax - 65'sd1;

  // control state
  logic               started_q;
  logic        [31:0] last_q, head_q;
  logic signed [47:0] x_q, y_q;

  // payload registers
  logic        [31:0] t_q, dt_q, q1_q;
  logic signed [15:0] v_q, w_q;
  logic signed [33:0] cx_q, cy_q, cz_q, c0_q, s0_q, c1_q, s1_q;
  logic               flip_q, neg_q;
  logic       [114:0] mcand_q, acc_q;
  logic        [57:0] mplier_q;
  logic        [63:0] num_q;
  logic        [19:0] rem_q, den_q;
  logic signed [63:0] dx_q, dy_q, dist_q;

  logic        [31:0] ang, bang;
  logic signed [33:0] xs, ys, tab;
  logic        [15:0] w_mag, v_mag;
  logic       [114:0] rsum;
  logic signed [50:0] nprod;
  logic        [50:0] nmag;
  logic        [56:0] zin;
  logic        [63:0] rq;
  logic        [20:0] rs;
  logic        [63:0] qneg, dmag;
  logic        [33:0] cmag;
  logic        [63:0] mres;
  logic signed [64:0] xsum, ysum;

  function automatic logic signed [47:0] sat48(input logic signed [64:0] s);
    logic signed [47:0] r;
    if (s > PosMax)      r = PosMax[47:0];
    else if (s < PosMin) r = PosMin[47:0];
    else                 r = s[47:0];
    return r;
  endfunction

  always_comb begin
    ang   = (cmd_i.op == OP_COR_INIT1) ? q1_q : head_q;
    bang  = (ang[31] ^ ang[30]) ? (ang + 32'h8000_0000) : ang;
    xs    = cx_q >>> cmd_i.idx;
    ys    = cy_q >>> cmd_i.idx;
    tab   = {2'b00, arc_angle(cmd_i.idx)};
    w_mag = w_q[15] ? 16'(-w_q) : 16'(w_q);
    v_mag = v_q[15] ? 16'(-v_q) : 16'(v_q);
    rsum  = acc_q + (115'd1 << 39);
    nprod = (cmd_i.op == OP_DIV_X) ? 51'(v_q * 35'(s1_q - s0_q))
                                   : 51'(v_q * 35'(c0_q - c1_q));
    nmag  = nprod[50] ? 51'(-nprod) : 51'(nprod);
    // |v|*dt*2^16/10^6 rounded equals floor((|v|*dt*2^10 + 7812) / 15625)
    zin   = {47'(v_mag * dt_q), 10'd0} + 57'd7812;
    rq    = 64'(acc_q[114:71]);
    rs    = {rem_q, num_q[63]};
    qneg  = 64'(-num_q);
    dmag  = dist_q[63] ? 64'(-dist_q) : 64'(dist_q);
    cmag  = (cmd_i.op == OP_SMUL_X) ? (c0_q[33] ? 34'(-c0_q) : 34'(c0_q))
                                    : (s0_q[33] ? 34'(-s0_q) : 34'(s0_q));
    mres  = 64'(acc_q[87:30] + 58'(acc_q[29]));
    xsum  = 65'(x_q) + 65'(dx_q);
    ysum  = 65'(y_q) + 65'(dy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      last_q    <= '0;
      head_q    <= '0;
      x_q       <= '0;
      y_q       <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_LOAD: begin
          if (!started_q) begin
            started_q <= 1'b1;
            x_q <= '0; y_q <= '0; head_q <= '0;
          end
        end
        OP_UPDATE: begin
          x_q    <= sat48(xsum);
          y_q    <= sat48(ysum);
          head_q <= q1_q;
          last_q <= t_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        t_q  <= sample_time_i;
        v_q  <= linear_speed_i;
        w_q  <= turn_rate_i;
        dt_q <= sample_time_i - last_q;
      end
      OP_COR_INIT0, OP_COR_INIT1: begin
        flip_q <= ang[31] ^ ang[30];
        cx_q   <= CordicStart;
        cy_q   <= '0;
        cz_q   <= 34'(signed'(bang));
      end
      OP_COR_STEP: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - tab;
        end else begin
          cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + tab;
        end
      end
      OP_SAVE0: begin
        c0_q <= flip_q ? -cx_q : cx_q;
        s0_q <= flip_q ? -cy_q : cy_q;
        q1_q <= head_q;
      end
      OP_SAVE1: begin
        c1_q <= flip_q ? -cx_q : cx_q;
        s1_q <= flip_q ? -cy_q : cy_q;
      end
      OP_MUL_HEAD: begin
        mcand_q  <= 115'(w_mag * dt_q);
        mplier_q <= 58'(HeadGain);
        acc_q    <= '0;
      end
      OP_SMUL_X, OP_SMUL_Y: begin
        mcand_q  <= 115'(dmag);
        mplier_q <= 58'(cmag);
        acc_q    <= '0;
        neg_q    <= dist_q[63] ^ ((cmd_i.op == OP_SMUL_X) ? c0_q[33] : s0_q[33]);
      end
      OP_MUL_STEP: begin
        if (mplier_q[0]) acc_q <= acc_q + mcand_q;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
      end
      OP_HEAD_Q1: begin
        q1_q <= w_q[15] ? (head_q - rsum[71:40]) : (head_q + rsum[71:40]);
      end
      OP_DIV_X, OP_DIV_Y: begin
        den_q <= {2'b00, w_mag, 2'b00};
        num_q <= 64'(nmag) + 64'({w_mag, 1'b0});
        neg_q <= nprod[50] ^ w_q[15];
        rem_q <= '0;
      end
      OP_DIV_S: begin
        mcand_q  <= 115'(zin);
        mplier_q <= RcpMul;
        acc_q    <= '0;
        neg_q    <= v_q[15];
      end
      OP_DIV_STEP: begin
        if (rs >= {1'b0, den_q}) begin
          rem_q <= 20'(rs - {1'b0, den_q});
          num_q <= {num_q[62:0], 1'b1};
        end else begin
          rem_q <= rs[19:0];
          num_q <= {num_q[62:0], 1'b0};
        end
      end
      OP_DIVX_DONE:  dx_q   <= neg_q ? qneg : num_q;
      OP_DIVY_DONE:  dy_q   <= neg_q ? qneg : num_q;
      OP_DIVS_DONE:  dist_q <= neg_q ? -rq : rq;
      OP_SMULX_DONE: dx_q   <= neg_q ? 64'(-mres) : mres;
      OP_SMULY_DONE: dy_q   <= neg_q ? 64'(-mres) : mres;
      default: ;
    endcase
  end

  assign status_o.started = started_q;
  assign status_o.w_zero  = (w_q == 16'sd0);
  assign pos_x_o   = x_q;
  assign pos_y_o   = y_q;
  assign heading_o = head_q;

endmodule

>>> src/velocity_motion_pose_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_motion_pose_update_unit: dead-reckoning pose tracker
// Takes odometry words and returns the pose after each one.
//
//   channel  direction  handshake            fields
//   in       input      in_valid / in_stall  sample_time, linear_speed, turn_rate
//   out      output     out_valid/out_stall  pos_x, pos_y, heading
//
// A turning sample runs two 30-step CORDIC passes, a 40-step heading multiply
// and two 64-step divides. A straight one runs one CORDIC pass, a 58-step
// reciprocal multiply and two 40-step multiplies. The first sample after reset
// is answered in the cycle after it is accepted. Reset clears the pose, the last
// timestamp and the started flag. The input stalls from acceptance until the
// result word has been taken; the next word can be accepted on the cycle after
// that.
// ----------------------------------------------------------------------------
module velocity_motion_pose_update_unit
  import vmpu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [31:0] sample_time_i,
  input  logic signed [15:0] linear_speed_i,
  input  logic signed [15:0] turn_rate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] pos_x_o,
  output logic signed [47:0] pos_y_o,
  output logic        [31:0] heading_o
);

  cmd_t    cmd;
  status_t status;

  vmpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vmpu_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_time_i  (sample_time_i),
    .linear_speed_i (linear_speed_i),
    .turn_rate_i    (turn_rate_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .heading_o      (heading_o)
  );

endmodule

>>> tb/sv/velocity_motion_pose_update_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_motion_pose_update_unit_tb: self-checking bench of the pose tracker
// Feeds odometry words through a gapped valid/stall driver, tracks the pose in
// a fixed-point shadow tracker and checks every pose word the block returns.
// ----------------------------------------------------------------------------
module velocity_motion_pose_update_unit_tb;
  import vmpu_pkg::*;

  typedef struct {
    logic [31:0] t;
    logic signed [15:0] v;
    logic signed [15:0] w;
  } odo_t;

  typedef struct {
    logic [47:0] x;
    logic [47:0] y;
    logic [31:0] h;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [31:0] sample_time_i = '0;
  logic signed [15:0] linear_speed_i = '0;
  logic signed [15:0] turn_rate_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o;
  logic signed [47:0] pos_x_o, pos_y_o;
  logic [31:0] heading_o;

  velocity_motion_pose_update_unit uut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  odo_t sample_q[$];
  pose_t pose_q[$];
  int errors = 0;
  int hold_off = 0;
  int rx_gap = 0;
  bit pause_req = 0;

  // shadow pose
  bit trk_started;
  logic [31:0] trk_time = '0;
  longint trk_x, trk_y;
  logic [31:0] trk_head;

  function automatic logic [31:0] atan_step(int i);
    logic [31:0] tab [30] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
    return tab[i];
  endfunction

  task automatic rotate(input logic [31:0] a, output longint c, output longint s);
    bit flip;
    logic [31:0] b;
    longint x, y, z, xs, ys;
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    b = flip ? a + 32'h80000000 : a;
    x = 652032874;
    y = 0;
    z = longint'($signed(b));
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_step(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_step(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint round_div(longint n, longint d);
    logic [63:0] mn, md, q;
    mn = n < 0 ? -n : n;
    md = d < 0 ? -d : d;
    q = (mn + md / 2) / md;
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [63:0] scale_round(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = a * b;
    p = (p + (128'd1 << (sh - 1))) >> sh;
    return p[63:0];
  endfunction

  function automatic longint clamp_add(longint a, longint b);
    longint r;
    r = a + b;
    if (r > 64'sh7FFFFFFFFFFF) return 64'sh7FFFFFFFFFFF;
    if (r < -64'sh800000000000) return -64'sh800000000000;
    return r;
  endfunction

  task automatic track_pose(input odo_t s, output pose_t p);
    longint dt, c0, s0, c1, s1, dx, dy, prod, run_len, v, w;
    logic [31:0] d, q1, dtw;
    v = s.v;
    w = s.w;
    if (!trk_started) begin
      trk_started = 1;
      trk_x = 0; trk_y = 0; trk_head = 0;
    end else begin
      dtw = s.t - trk_time;
      dt = longint'(dtw);
      rotate(trk_head, c0, s0);
      if (w != 0) begin
        prod = w * dt;
        d = 32'(scale_round(prod < 0 ? -prod : prod, 64'd183493156455, 40));
        if (prod < 0) d = -d;
        q1 = trk_head + d;
        rotate(q1, c1, s1);
        dx = round_div(v * (s1 - s0), 4 * w);
        dy = round_div(v * (c0 - c1), 4 * w);
        trk_head = q1;
      end else begin
        run_len = round_div(v * dt * 65536, 1000000);
        dx = scale_round(run_len < 0 ? -run_len : run_len, c0 < 0 ? -c0 : c0, 30);
        dy = scale_round(run_len < 0 ? -run_len : run_len, s0 < 0 ? -s0 : s0, 30);
        if ((run_len < 0) != (c0 < 0)) dx = -dx;
        if ((run_len < 0) != (s0 < 0)) dy = -dy;
      end
      trk_x = clamp_add(trk_x, dx);
      trk_y = clamp_add(trk_y, dy);
      trk_time = s.t;
    end
    p.x = trk_x[47:0];
    p.y = trk_y[47:0];
    p.h = trk_head;
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
  endfunction

  // driver
  always @(posedge clk_i) begin
    pose_t p;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        track_pose(sample_q.pop_front(), p);
        pose_q.push_back(p);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (hold_off > 0 || pause_req || sample_q.size() == 0) begin
          in_valid_i <= 1'b0;
          if (hold_off > 0) hold_off <= hold_off - 1;
        end else begin
          in_valid_i <= 1'b1;
          sample_time_i <= sample_q[0].t;
          linear_speed_i <= sample_q[0].v;
          turn_rate_i <= sample_q[0].w;
          hold_off <= gap_len();
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pose_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected pose word x=%h", pos_x_o);
        end else begin
          e = pose_q.pop_front();
          if (pos_x_o !== e.x || pos_y_o !== e.y || heading_o !== e.h) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: pose exp x=%h y=%h h=%h got x=%h y=%h h=%h",
                       e.x, e.y, e.h, pos_x_o, pos_y_o, heading_o);
          end
        end
      end
      if (rx_gap > 0) begin
        out_stall_i <= 1'b1;
        rx_gap <= rx_gap - 1;
      end else begin
        out_stall_i <= 1'b0;
        rx_gap <= ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      end
    end
  end

  task automatic add_sample(logic [31:0] t, logic [15:0] v, logic [15:0] w);
    odo_t s;
    s.t = t; s.v = v; s.w = w;
    sample_q.push_back(s);
  endtask

  initial begin
    logic [31:0] t;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // first sample only zeroes the pose
    add_sample(32'd5000, 16'sh7FFF, 16'sh7FFF);
    add_sample(32'd20000, 16'sd1000, 16'sd0);
    add_sample(32'd40000, 16'sd1000, 16'sd4096);
    add_sample(32'd40001, 16'sd500, 16'sd1);
    add_sample(32'd10, -16'sd2000, -16'sd3000);
    add_sample(32'hFFFFFFFF, 16'sh7FFF, 16'sd0);
    add_sample(32'hFFFFFFF0, 16'sh8000, 16'sh8000);
    add_sample(32'd100, 16'sh8000, 16'sh7FFF);
    add_sample(32'h7FFFFFFF, 16'sh7FFF, 16'sd0);
    add_sample(32'hFFFFFFFF, 16'sh7FFF, 16'sd0);
    add_sample(32'h7FFFFFFF, 16'sh7FFF, 16'sd0);
    add_sample(32'hFFFFFFFF, 16'sh7FFF, 16'sd0);
    add_sample(32'h7FFFFFFF, 16'sh8000, 16'sd0);
    add_sample(32'h7FFFFF00, 16'sd0, 16'sd1);
    add_sample(32'h7FFFFF01, 16'sd300, -16'sd1);
    add_sample(32'h00000000, 16'sh8000, 16'sh8000);
    t = 0;
    for (int i = 0; i < 1000; i++) begin
      int k;
      logic [15:0] vv, ww;
      k = $urandom_range(0, 9);
      t += (k == 0) ? $urandom() : $urandom_range(1000, 50000);
      vv = (k < 7) ? 16'($urandom_range(0, 4000) - 2000) : 16'($urandom());
      ww = (k < 3) ? 16'd0 : (k < 8) ? 16'($urandom_range(0, 8000) - 4000)
                                      : 16'($urandom());
      add_sample(t, vv, ww);
      if (i == 500) begin
        wait (sample_q.size() <= 400);
        pause_req = 1;
        wait (pose_q.size() == 0 && !in_valid_i);
        @(posedge clk_i);
        pause_req = 0;
      end
    end
    wait (sample_q.size() == 0 && pose_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
